FILE: rtl/tptl_pkg.sv
// types and constants shared by the temperature peak and trend logger
// no dependencies
`default_nettype none

package tptl_pkg;

   localparam int RawW     = 15;
   localparam int SecW     = 32;
   localparam int StampW   = 36;
   localparam int TempW    = 14;
   localparam int ThrW     = 10;
   localparam int LimW     = 8;
   localparam int DayLsb   = 14;
   localparam int DayW     = 5;
   localparam int ReqDataW = 88;
   localparam int RspDataW = 104;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 32;

   // rejected readings; zero and 8500, both within the signed reading
   localparam logic signed [RawW-1:0] RawBadZero = 15'sd0;
   localparam logic signed [RawW-1:0] RawBadInit = 15'sd8500;

   localparam logic [LimW-1:0] CountMax = 8'd255;

   localparam logic [ThrW-1:0] RiseThresholdRst  = 10'd18;
   localparam logic [LimW-1:0] StableLimitRst    = 8'd30;
   localparam logic [SecW-1:0] ArchiveHoldoffRst = 32'd60;

   localparam logic [CsrIdxW-1:0] CsrRiseThreshold  = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrStableLimit    = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrArchiveHoldoff = 2'd2;

   typedef enum logic [1:0] {
      TREND_STEADY  = 2'd0,
      TREND_RISING  = 2'd1,
      TREND_FALLING = 2'd2
   } trend_type;

   typedef struct packed {
      logic [ThrW-1:0] rise_threshold;
      logic [LimW-1:0] stable_limit;
      logic [SecW-1:0] archive_holdoff;
   } cfg_type;

   // last field in the lowest bits, as on the stream
   typedef struct packed {
      logic [StampW-1:0]      stamp;
      logic [SecW-1:0]        now_seconds;
      logic signed [RawW-1:0] raw_temp;
   } sample_type;

   typedef struct packed {
      logic [StampW-1:0] archived_stamp;
      logic [TempW-1:0]  archived_temp;
      logic [StampW-1:0] peak_stamp;
      logic [TempW-1:0]  peak_temp;
      trend_type         trend;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/tptl_csr.sv
// configuration registers of the logger
// depends on tptl_pkg
`default_nettype none

module tptl_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [tptl_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [tptl_pkg::CsrDataW-1:0] csr_wdata,
   output tptl_pkg::cfg_type                 cfg
);
   import tptl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CsrRiseThreshold:  cfg_in.rise_threshold  = csr_wdata[ThrW-1:0];
            CsrStableLimit:    cfg_in.stable_limit    = csr_wdata[LimW-1:0];
            CsrArchiveHoldoff: cfg_in.archive_holdoff = csr_wdata[SecW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_threshold  <= RiseThresholdRst;
         cfg_ff.stable_limit    <= StableLimitRst;
         cfg_ff.archive_holdoff <= ArchiveHoldoffRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/tptl_core.sv
// trend, peak and archive state with the per-item update logic
// depends on tptl_pkg
`default_nettype none

module tptl_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire tptl_pkg::sample_type sample,
   input  wire tptl_pkg::cfg_type    cfg,
   output tptl_pkg::result_type      result
);
   import tptl_pkg::*;

   logic signed [RawW-1:0] last_good_ff, last_good_in;
   logic signed [RawW-1:0] prev_temp_ff, prev_temp_in;
   trend_type              trend_ff, trend_in;
   logic [LimW-1:0]        count_ff, count_in;
   logic [TempW-1:0]       peak_ff, peak_in;
   logic [StampW-1:0]      peak_time_ff, peak_time_in;
   logic [TempW-1:0]       archive_ff, archive_in;
   logic [StampW-1:0]      archive_time_ff, archive_time_in;
   logic [SecW-1:0]        last_archive_ff, last_archive_in;

   logic                   raw_ok;
   logic                   clock_ok;
   logic signed [RawW-1:0] temp;
   logic signed [RawW+1:0] temp_wide;
   logic signed [RawW+1:0] jump_level;
   logic [SecW-1:0]        elapsed;
   logic                   peak_pos;
   logic                   jump;
   logic                   archive_take;
   logic                   count_up;
   logic [LimW-1:0]        count_a;
   logic                   settle;
   logic [TempW-1:0]       peak_a;
   logic                   peak_take;

   always_comb begin
      raw_ok       = (sample.raw_temp != RawBadZero) && (sample.raw_temp != RawBadInit);
      temp         = raw_ok ? sample.raw_temp : last_good_ff;
      clock_ok     = |sample.stamp[DayLsb +: DayW];
      peak_pos     = (peak_ff != '0);
      temp_wide    = {{2{temp[RawW-1]}}, temp};
      jump_level   = {{2{prev_temp_ff[RawW-1]}}, prev_temp_ff}
                   + $signed({{(RawW+2-ThrW){1'b0}}, cfg.rise_threshold});
      jump         = clock_ok && peak_pos && (temp_wide > jump_level);
      elapsed      = sample.now_seconds - last_archive_ff;
      archive_take = jump && (elapsed > cfg.archive_holdoff);

      count_up = clock_ok && (trend_ff != TREND_STEADY) && (temp == prev_temp_ff)
               && (count_ff != CountMax);
      count_a  = count_up ? count_ff + 8'd1 : count_ff;
      settle   = (trend_ff != TREND_STEADY) && (count_a > cfg.stable_limit);
      count_in = settle ? '0 : count_a;

      trend_in = settle ? TREND_STEADY : trend_ff;
      if (clock_ok && peak_pos && (temp > prev_temp_ff)) begin
         trend_in = TREND_RISING;
      end
      if (clock_ok && (temp < prev_temp_ff)) begin
         trend_in = TREND_FALLING;
      end

      peak_a       = jump ? '0 : peak_ff;
      peak_take    = clock_ok && (temp > $signed({1'b0, peak_a}));
      peak_in      = peak_take ? temp[TempW-1:0] : peak_a;
      peak_time_in = peak_take ? sample.stamp : peak_time_ff;

      archive_in      = archive_take ? peak_ff : archive_ff;
      archive_time_in = archive_take ? peak_time_ff : archive_time_ff;
      last_archive_in = archive_take ? sample.now_seconds : last_archive_ff;

      prev_temp_in = clock_ok ? temp : prev_temp_ff;
      last_good_in = raw_ok ? sample.raw_temp : last_good_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_good_ff    <= '0;
         prev_temp_ff    <= '0;
         trend_ff        <= TREND_STEADY;
         count_ff        <= '0;
         peak_ff         <= '0;
         peak_time_ff    <= '0;
         archive_ff      <= '0;
         archive_time_ff <= '0;
         last_archive_ff <= '0;
      end else if (step) begin
         last_good_ff    <= last_good_in;
         prev_temp_ff    <= prev_temp_in;
         trend_ff        <= trend_in;
         count_ff        <= count_in;
         peak_ff         <= peak_in;
         peak_time_ff    <= peak_time_in;
         archive_ff      <= archive_in;
         archive_time_ff <= archive_time_in;
         last_archive_ff <= last_archive_in;
      end
   end

   assign result.trend          = trend_in;
   assign result.peak_temp      = peak_in;
   assign result.peak_stamp     = peak_time_in;
   assign result.archived_temp  = archive_in;
   assign result.archived_stamp = archive_time_in;

   // no clock, no change to sample history or peaks
   a_no_clock_hold: assert property (@(posedge clock) disable iff (reset)
      (step && !clock_ok) |=> ($stable(prev_temp_ff) && $stable(peak_ff)
                               && $stable(archive_ff)))
      else $error("state moved while stamp day was zero");

   a_prev_follows: assert property (@(posedge clock) disable iff (reset)
      (step && clock_ok) |=> (prev_temp_ff == $past(temp)))
      else $error("previous sample not taken");

   a_archive_time: assert property (@(posedge clock) disable iff (reset)
      (step && archive_take) |=> ((last_archive_ff == $past(sample.now_seconds))
                                  && (archive_ff == $past(peak_ff))))
      else $error("archive capture inconsistent");

endmodule

`default_nettype wire

FILE: rtl/temperature_peak_trend_logger.sv
// top level of the temperature peak and trend logger: input and result registers
// depends on tptl_pkg, tptl_csr, tptl_core
//
//   channel  ports     direction  contents
//   req      req_t*    in         raw_temp, now_seconds, stamp
//   rsp      rsp_t*    out        trend, peak_temp, peak_stamp, archived_temp, archived_stamp
//   csr      csr_*     in         rise_threshold, stable_limit, archive_holdoff
//
// one item per cycle sustained while rsp is not stalled; an accepted req reaches rsp valid through
// the input register, then the single update stage into the result register
// reset clears both valid flags, all history state and loads register defaults
// a stalled rsp holds the result and the input register, then req_tready drops
`default_nettype none

module temperature_peak_trend_logger (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // raw_temp, now_seconds, stamp, zero fill
   input  wire logic [tptl_pkg::ReqDataW-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // trend, peak_temp, peak_stamp, archived_temp, archived_stamp, zero fill
   output logic [tptl_pkg::RspDataW-1:0]      rsp_tdata,
   input  wire logic                          csr_we,
   input  wire logic [tptl_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [tptl_pkg::CsrDataW-1:0] csr_wdata
);
   import tptl_pkg::*;

   localparam int SampleW = $bits(sample_type);
   localparam int ResultW = $bits(result_type);

   logic       in_valid_ff, in_valid_in;
   sample_type in_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   logic       req_fire;
   logic       advance;
   cfg_type    cfg;
   result_type result;

   tptl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tptl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .sample (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || advance;
      req_fire   = req_tvalid && req_tready;

      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_tdata[SampleW-1:0];
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW-ResultW){1'b0}}, rsp_data_ff};

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item did not reach the result register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while both stages are full");

   // a waiting result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("result changed while stalled");

endmodule

`default_nettype wire
